// File: sv/set_assoc_cache_lru_sim_top_macros.svh
// Assertion helpers for the cache tag simulator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SET_ASSOC_CACHE_LRU_SIM_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sacl_pkg.sv
package sacl_pkg;

  // Geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
  localparam int AGE_W        = 3;
  localparam int AGE_MAX      = (1 << AGE_W) - 1;
  localparam int CNT_W        = 32;
  localparam int SBITS_W      = 3;
  localparam int OFF_W        = 5;
  localparam int CWAYS_W      = 4;
  localparam int TSH_W        = OFF_W + 1;

  // Reserved command: accepted, no lookup, no result
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LK
  } state_t;

  // One way of a set: valid, recency rank (0 = newest), tag
  typedef struct packed {
    logic                  valid;
    logic [AGE_W-1:0]      age;
    logic [ADDR_WIDTH-1:0] tag;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [SBITS_W-1:0] sbits;
    logic [OFF_W-1:0]   off;
    logic [WAYS_W-1:0]  ways;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic rd;
    logic lk;
    logic last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/sacl_if.sv
interface sacl_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [sacl_pkg::ADDR_WIDTH-1:0]   address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface sacl_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    outcome;
  logic [sacl_pkg::CNT_W-1:0]    hit_total;
  logic [sacl_pkg::CNT_W-1:0]    miss_total;
  logic [sacl_pkg::CNT_W-1:0]    eviction_total;
  logic                          last;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, output last, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, input last, output ready);
endinterface

// File: sv/sacl_ram.sv
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sacl_ctrl.sv
module sacl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_cmd,
  output logic                 in_ready,
  input  sacl_pkg::dp_stat_t   stat,
  output sacl_pkg::ctrl_cmd_t  cmd
);

  sacl_pkg::state_t state_r, state_nxt;
  logic is_mod_r, is_mod_nxt;
  logic second_r, second_nxt;
  logic known_cmd;

  assign known_cmd = in_cmd inside {sacl_pkg::CMD_LOAD, sacl_pkg::CMD_STORE,
                                    sacl_pkg::CMD_MODIFY};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacl_pkg::S_IDLE: begin
        if (in_valid && known_cmd) state_nxt = sacl_pkg::S_RD;
      end
      sacl_pkg::S_RD: begin
        state_nxt = sacl_pkg::S_LK;
      end
      sacl_pkg::S_LK: begin
        if (stat.out_free) state_nxt = cmd.last ? sacl_pkg::S_IDLE : sacl_pkg::S_RD;
      end
      default: state_nxt = sacl_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.last = !(is_mod_r && !second_r);
    case (state_r)
      sacl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid && known_cmd;
      end
      sacl_pkg::S_RD: begin
        cmd.rd = 1'b1;
      end
      sacl_pkg::S_LK: begin
        cmd.lk = stat.out_free;
      end
      default: ;
    endcase
  end

  // Track modify and which of its two lookups is running
  always_comb begin
    is_mod_nxt = is_mod_r;
    second_nxt = second_r;
    if (cmd.cap) begin
      is_mod_nxt = (in_cmd == sacl_pkg::CMD_MODIFY);
      second_nxt = 1'b0;
    end else if (cmd.lk && !cmd.last) begin
      second_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sacl_pkg::S_IDLE;
      is_mod_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_mod_r <= is_mod_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: sv/sacl_dpath.sv
module sacl_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sacl_pkg::cfg_t                      cfg,
  input  sacl_pkg::ctrl_cmd_t                 cmd,
  output sacl_pkg::dp_stat_t                  stat,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0]     in_address,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_outcome,
  output logic [sacl_pkg::CNT_W-1:0]          out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]          out_miss_total,
  output logic [sacl_pkg::CNT_W-1:0]          out_eviction_total,
  output logic                                out_last
);

  localparam int NW = sacl_pkg::MAX_WAYS;
  localparam logic [sacl_pkg::CNT_W-1:0] CNT_SAT = '1;

  logic [sacl_pkg::ADDR_WIDTH-1:0] addr_r;
  logic [sacl_pkg::ADDR_WIDTH-1:0] tag_r, tag_calc, shifted;
  logic [sacl_pkg::SET_W-1:0]      set_r, set_calc, set_mask;
  logic [sacl_pkg::TSH_W-1:0]      tshift;
  logic                            rinit_r;
  logic [sacl_pkg::NUM_SETS-1:0]   row_init_r;
  sacl_pkg::row_t                  row_rd, row_new;

  logic [NW-1:0]                   in_use, vld, hit, empty;
  logic                            hit_any, empty_any, vic_found;
  logic [sacl_pkg::WAY_IDX_W-1:0]  hw, ew, vic, tgt;
  logic [sacl_pkg::AGE_W-1:0]      hit_age, best_age;
  logic [1:0]                      outcome;

  logic [sacl_pkg::CNT_W-1:0] hit_r, miss_r, evict_r;
  logic [sacl_pkg::CNT_W-1:0] hit_nxt, miss_nxt, evict_nxt;
  logic                       out_valid_r;
  logic [1:0]                 outcome_r;
  logic                       last_r;

  // Address split: set index and tag
  always_comb begin
    shifted  = addr_r >> cfg.off;
    set_mask = sacl_pkg::SET_W'((1 << cfg.sbits) - 1);
    set_calc = shifted[sacl_pkg::SET_W-1:0] & set_mask;
    tshift   = sacl_pkg::TSH_W'(cfg.off) + sacl_pkg::TSH_W'(cfg.sbits);
    tag_calc = addr_r >> tshift;
  end

  // Capture the address, then the set and tag at read time
  always_ff @(posedge clk) begin
    if (cmd.cap) addr_r <= in_address;
    if (cmd.rd) begin
      set_r   <= set_calc;
      tag_r   <= tag_calc;
      rinit_r <= row_init_r[set_calc];
    end
  end

  sacl_ram #(
    .WIDTH ($bits(sacl_pkg::row_t)),
    .DEPTH (sacl_pkg::NUM_SETS)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.lk),
    .waddr (set_r),
    .wdata (row_new),
    .re    (cmd.rd),
    .raddr (set_calc),
    .rdata (row_rd)
  );

  // Per-way match, empty and in-use flags
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      in_use[w] = (w < int'(cfg.ways));
      vld[w]    = rinit_r && row_rd[w].valid;
      hit[w]    = in_use[w] && vld[w] && (row_rd[w].tag == tag_r);
      empty[w]  = in_use[w] && !vld[w];
    end
    hit_any   = |hit;
    empty_any = |empty;
  end

  // Lowest matching way, lowest empty way, oldest valid way
  always_comb begin
    hw        = '0;
    ew        = '0;
    vic       = '0;
    best_age  = '0;
    vic_found = 1'b0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (hit[w]) hw = sacl_pkg::WAY_IDX_W'(w);
      if (empty[w]) ew = sacl_pkg::WAY_IDX_W'(w);
    end
    for (int w = 0; w < NW; w++) begin
      if (in_use[w] && vld[w] && (!vic_found || row_rd[w].age > best_age)) begin
        best_age  = row_rd[w].age;
        vic       = sacl_pkg::WAY_IDX_W'(w);
        vic_found = 1'b1;
      end
    end
    hit_age = row_rd[hw].age;
    tgt     = empty_any ? ew : vic;
  end

  // Updated row and outcome
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      row_new[w]       = row_rd[w];
      row_new[w].valid = vld[w];
      if (hit_any) begin
        if (sacl_pkg::WAY_IDX_W'(w) == hw) begin
          row_new[w].age = '0;
        end else if (in_use[w] && vld[w] && row_rd[w].age < hit_age &&
                     int'(row_rd[w].age) < sacl_pkg::AGE_MAX) begin
          row_new[w].age = row_rd[w].age + 1'b1;
        end
      end else begin
        if (sacl_pkg::WAY_IDX_W'(w) == tgt) begin
          row_new[w].valid = 1'b1;
          row_new[w].tag   = tag_r;
          row_new[w].age   = '0;
        end else if (in_use[w] && vld[w] &&
                     int'(row_rd[w].age) < sacl_pkg::AGE_MAX) begin
          row_new[w].age = row_rd[w].age + 1'b1;
        end
      end
    end
    if (hit_any)        outcome = sacl_pkg::OUT_HIT;
    else if (empty_any) outcome = sacl_pkg::OUT_FILL;
    else                outcome = sacl_pkg::OUT_EVICT;
  end

  // Saturating counters
  always_comb begin
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    evict_nxt = evict_r;
    if (cmd.lk) begin
      if (hit_any) begin
        if (hit_r != CNT_SAT) hit_nxt = hit_r + 1'b1;
      end else begin
        if (miss_r != CNT_SAT) miss_nxt = miss_r + 1'b1;
        if (!empty_any && evict_r != CNT_SAT) evict_nxt = evict_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= '0;
      miss_r     <= '0;
      evict_r    <= '0;
      row_init_r <= '0;
    end else begin
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      evict_r <= evict_nxt;
      if (cmd.lk) row_init_r[set_r] <= 1'b1;
    end
  end

  // Output register: load on lookup, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.lk) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lk) begin
      outcome_r <= outcome;
      last_r    <= cmd.last;
    end
  end

  assign stat.out_free      = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_hit_total      = hit_r;
  assign out_miss_total     = miss_r;
  assign out_eviction_total = evict_r;
  assign out_last           = last_r;

endmodule

// File: sv/set_assoc_cache_lru_sim_top.sv
// Load and store: a row read, then a lookup and write-back that registers the result;
// modify runs two such lookups and gives two results. One tag-row read-modify-write
// in the row RAM per lookup; a new item is accepted only when the last is done, and a
// lookup waits for a free output slot. Unknown commands give no lookup and no result.
// Reset (rst_n low, synchronous): counters clear, every set reads as empty through
// per-set init flags, registers return to 0 set bits, 0 offset bits, 1 way.
`include "set_assoc_cache_lru_sim_top_macros.svh"

module set_assoc_cache_lru_sim_top (
  input  logic              clk,
  input  logic              rst_n,
  sacl_in_if.sink           in_ch,
  sacl_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [sacl_pkg::SBITS_W-1:0] sbits_r;
  logic [sacl_pkg::OFF_W-1:0]   off_r;
  logic [sacl_pkg::CWAYS_W-1:0] ways_r;
  sacl_pkg::reg_idx_t           reg_idx;
  logic                         cfg_wr;
  sacl_pkg::cfg_t               cfg;
  sacl_pkg::ctrl_cmd_t          dp_cmd;
  sacl_pkg::dp_stat_t           dp_stat;

  assign pready  = 1'b1;
  assign reg_idx = sacl_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbits_r <= '0;
      off_r   <= '0;
      ways_r  <= sacl_pkg::CWAYS_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        sacl_pkg::REG_SET_BITS:    sbits_r <= pwdata[sacl_pkg::SBITS_W-1:0];
        sacl_pkg::REG_OFFSET_BITS: off_r   <= pwdata[sacl_pkg::OFF_W-1:0];
        sacl_pkg::REG_WAYS:        ways_r  <= pwdata[sacl_pkg::CWAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      sacl_pkg::REG_SET_BITS:    prdata = 32'(sbits_r);
      sacl_pkg::REG_OFFSET_BITS: prdata = 32'(off_r);
      sacl_pkg::REG_WAYS:        prdata = 32'(ways_r);
      default:                   prdata = '0;
    endcase
  end

  // Clamp set bits and way count to the built geometry
  always_comb begin
    cfg.off   = off_r;
    cfg.sbits = (int'(sbits_r) > sacl_pkg::MAX_SET_BITS) ?
                sacl_pkg::SBITS_W'(sacl_pkg::MAX_SET_BITS) : sbits_r;
    if (ways_r == '0)
      cfg.ways = sacl_pkg::WAYS_W'(1);
    else if (int'(ways_r) > sacl_pkg::MAX_WAYS)
      cfg.ways = sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS);
    else
      cfg.ways = sacl_pkg::WAYS_W'(ways_r);
  end

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  sacl_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .in_address         (in_ch.address),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_outcome        (out_ch.outcome),
    .out_hit_total      (out_ch.hit_total),
    .out_miss_total     (out_ch.miss_total),
    .out_eviction_total (out_ch.eviction_total),
    .out_last           (out_ch.last)
  );

  // A lookup never overwrites a result that is still waiting
  `SACL_ASSERT_NOW(a_lk_slot_free, dp_cmd.lk, !out_ch.valid || out_ch.ready,
                   "lookup over held result")
  // An accepted known command starts a row read next cycle
  `SACL_ASSERT_NEXT(a_cap_reads,
                    in_ch.valid && in_ch.ready && in_ch.cmd != sacl_pkg::CMD_RSVD,
                    dp_cmd.rd, "no row read after accept")
  // The first result of a modify is shown only while its second lookup is pending
  `SACL_ASSERT_NOW(a_mid_busy, out_ch.valid && !out_ch.last, !in_ch.ready,
                   "idle with modify half done")

endmodule
